FILE: hw/rtl/bis_pkg.sv
// Shared constants, widths and codes of the bilinear image scaler.
package bis_pkg;

    // Default store geometry, handed to the top level parameters
    localparam int DEF_MAX_SOURCE_WIDTH  = 256;
    localparam int DEF_MAX_SOURCE_HEIGHT = 256;
    localparam int PIXEL_CHANNELS        = 3;

    // Field widths
    localparam int COORD_W    = 12;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = PIXEL_CHANNELS * CHAN_W;
    localparam int SRC_SIZE_W = 9;
    localparam int DST_SIZE_W = 13;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DST_SIZE_W;

    // Reset values of the size registers
    localparam logic [SRC_SIZE_W-1:0] RST_SRC_SIZE = SRC_SIZE_W'(256);
    localparam logic [DST_SIZE_W-1:0] RST_DST_SIZE = DST_SIZE_W'(256);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_DST_WIDTH  = 2'd2,
        CFG_DST_HEIGHT = 2'd3
    } t_cfg_idx;

    // Transaction modes
    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_READ  = 1'b1
    } t_mode;

endpackage

FILE: hw/rtl/bis_if.sv
// Stream and configuration channel interfaces of the bilinear image scaler.
interface bis_in_if
    import bis_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;

    modport source (output valid, mode, column, line, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, mode, column, line, red_in, green_in, blue_in,
                    output ready);
endinterface

interface bis_out_if
    import bis_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              bad_request;

    modport source (output valid, red_out, green_out, blue_out, bad_request,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, bad_request,
                    output ready);
endinterface

interface bis_cfg_if
    import bis_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bilinear_image_scaler_top.sv
// Top level of the bilinear image scaler: image store, coordinate divider and blend unit.
//
//   channel   dir   handshake          payload
//   i_pix     in    valid / ready      mode, column, line, red_in, green_in, blue_in
//   o_pix     out   valid / ready      red_out, green_out, blue_out, bad_request
//   i_cfg     in    valid / ready      index, data (size registers)
//
// A pixel write goes into the image store when it is taken. A pixel request passes, for
// each source axis, through setup and the one-bit-per-cycle divider that maps it, then
// through the fetch of the four neighbours and a multiply and round per channel before
// it reaches the output register. A request outside the destination size goes from idle
// straight to the done state. Reset is synchronous and clears control state only; the
// image store is not cleared. A stalled output holds its transaction while the next input
// transaction is already being taken.
module bilinear_image_scaler_top
    import bis_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
    parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bis_in_if.sink     i_pix,
    bis_out_if.source  o_pix,
    bis_cfg_if.sink    i_cfg
);

    // Geometry
    localparam int XW    = (MAX_SOURCE_WIDTH  > 1) ? $clog2(MAX_SOURCE_WIDTH)  : 1;
    localparam int YW    = (MAX_SOURCE_HEIGHT > 1) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
    localparam int IW    = (XW > YW) ? XW : YW;
    localparam int DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = COORD_W + IW;
    localparam int DW    = PW + FRAC_W;
    localparam int CW    = $clog2(DW + 1);
    localparam int MUL_AW = 25;
    localparam int MUL_BW = FRAC_W + 1;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [AW-1:0]         ROW_STRIDE = AW'(MAX_SOURCE_WIDTH);
    localparam logic [DST_SIZE_W-1:0] MAX_W_C    = DST_SIZE_W'(MAX_SOURCE_WIDTH);
    localparam logic [DST_SIZE_W-1:0] MAX_H_C    = DST_SIZE_W'(MAX_SOURCE_HEIGHT);
    localparam logic [CW-1:0]         DIV_STEPS  = CW'(DW);
    localparam logic [1:0]            LAST_CH    = 2'(PIXEL_CHANNELS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_FETCH,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM_N,
        ST_MUL_Y,
        ST_ROUND,
        ST_DONE
    } t_state;

    // Channel byte of a packed pixel, red first
    function automatic logic [CHAN_W-1:0] chan_of(input logic [PIXEL_W-1:0] p,
                                                  input logic [1:0] c);
        logic [CHAN_W-1:0] res;
        case (c)
            2'd0:    res = p[23:16];
            2'd1:    res = p[15:8];
            default: res = p[7:0];
        endcase
        return res;
    endfunction

    // Size registers
    logic [SRC_SIZE_W-1:0] r_sw, r_sh;
    logic [DST_SIZE_W-1:0] r_tw, r_th;

    // Sequencer and datapath registers
    t_state                 r_state;
    logic                   r_axis;
    logic [COORD_W-1:0]     r_col, r_row;
    logic [DW-1:0]          r_dvd;
    logic [DST_SIZE_W-1:0]  r_rem;
    logic [DST_SIZE_W-1:0]  r_div;
    logic [CW-1:0]          r_dcnt;
    logic [IW-1:0]          r_x0, r_x1, r_y0, r_y1;
    logic [FRAC_W-1:0]      r_fx, r_fy;
    logic [2:0]             r_fcnt;
    logic [PIXEL_W-1:0]     r_pix [4];
    logic [1:0]             r_ch;
    logic signed [MUL_PW-1:0] r_prod;
    logic signed [MUL_AW-1:0] r_s, r_n;
    logic [CHAN_W-1:0]      r_res [3];
    logic                   r_bad;

    // Output register
    logic                   r_out_valid;
    logic [CHAN_W-1:0]      r_out_r, r_out_g, r_out_b;
    logic                   r_out_bad;

    // Image store
    logic [PIXEL_W-1:0]     r_mem [DEPTH];
    logic [PIXEL_W-1:0]     r_rd_data;

    // Handshakes
    logic in_acc, cfg_acc, out_acc;
    assign i_pix.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc  = i_pix.valid && i_pix.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign out_acc = o_pix.valid && o_pix.ready;

    assign o_pix.valid       = r_out_valid;
    assign o_pix.red_out     = r_out_r;
    assign o_pix.green_out   = r_out_g;
    assign o_pix.blue_out    = r_out_b;
    assign o_pix.bad_request = r_out_bad;

    // Clamped source sizes and their extents (size - 1)
    logic [DST_SIZE_W-1:0] sw_cl, sh_cl;
    logic [IW-1:0]         s_ex_x, s_ex_y;
    always_comb begin
        if (r_sw == '0) begin
            sw_cl = DST_SIZE_W'(1);
        end else if (DST_SIZE_W'(r_sw) > MAX_W_C) begin
            sw_cl = MAX_W_C;
        end else begin
            sw_cl = DST_SIZE_W'(r_sw);
        end
        if (r_sh == '0) begin
            sh_cl = DST_SIZE_W'(1);
        end else if (DST_SIZE_W'(r_sh) > MAX_H_C) begin
            sh_cl = MAX_H_C;
        end else begin
            sh_cl = DST_SIZE_W'(r_sh);
        end
        s_ex_x = IW'(sw_cl - DST_SIZE_W'(1));
        s_ex_y = IW'(sh_cl - DST_SIZE_W'(1));
    end

    // Per-axis operand selection for the shared divider
    logic [IW-1:0]         s_ex_sel;
    logic [DST_SIZE_W-1:0] d_ex_sel;
    logic [COORD_W-1:0]    coord_sel;
    always_comb begin
        if (r_axis) begin
            s_ex_sel  = s_ex_y;
            d_ex_sel  = r_th - DST_SIZE_W'(1);
            coord_sel = r_row;
        end else begin
            s_ex_sel  = s_ex_x;
            d_ex_sel  = r_tw - DST_SIZE_W'(1);
            coord_sel = r_col;
        end
    end

    // Request checks on the incoming transaction
    logic req_bad, wr_in_range;
    assign req_bad = ({1'b0, i_pix.column} >= r_tw) || ({1'b0, i_pix.line} >= r_th);
    assign wr_in_range = ({1'b0, i_pix.column} < MAX_W_C) && ({1'b0, i_pix.line} < MAX_H_C);

    // Divider step: one quotient bit a cycle
    logic [DST_SIZE_W:0] div_trial;
    logic                div_ge;
    assign div_trial = {r_rem, r_dvd[DW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_div});

    // Axis result from the finished quotient
    logic          ax_zero;
    logic [IW-1:0] ax_idx, ax_lo, ax_hi;
    logic [FRAC_W-1:0] ax_frac;
    always_comb begin
        ax_zero = (s_ex_sel == '0) || (r_div == '0);
        ax_idx  = r_dvd[FRAC_W +: IW];
        if (ax_zero) begin
            ax_lo   = '0;
            ax_hi   = '0;
            ax_frac = '0;
        end else begin
            ax_lo   = ax_idx;
            ax_hi   = (ax_idx >= s_ex_sel) ? ax_idx : ax_idx + IW'(1);
            ax_frac = r_dvd[FRAC_W-1:0];
        end
    end

    // Store addressing, single port: a write wins over the fetch read
    logic          mem_we;
    logic [AW-1:0] wr_addr, rd_addr, mem_addr;
    logic [IW-1:0] rd_x, rd_y;
    always_comb begin
        mem_we  = in_acc && (t_mode'(i_pix.mode) == MODE_WRITE) && wr_in_range;
        wr_addr = AW'(AW'(i_pix.line[YW-1:0]) * ROW_STRIDE) + AW'(i_pix.column[XW-1:0]);
        rd_x    = r_fcnt[0] ? r_x1 : r_x0;
        rd_y    = r_fcnt[1] ? r_y1 : r_y0;
        rd_addr = AW'(AW'(rd_y[YW-1:0]) * ROW_STRIDE) + AW'(rd_x[XW-1:0]);
        mem_addr = mem_we ? wr_addr : rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        end
        r_rd_data <= r_mem[mem_addr];
    end

    // Shared multiplier operands
    logic [CHAN_W-1:0]        a0, a1, b0, b1;
    logic signed [CHAN_W:0]   diff_a, diff_b;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic [MUL_PW-1:0]        round_v;
    always_comb begin
        a0 = chan_of(r_pix[0], r_ch);
        a1 = chan_of(r_pix[1], r_ch);
        b0 = chan_of(r_pix[2], r_ch);
        b1 = chan_of(r_pix[3], r_ch);
        diff_a = $signed({1'b0, a1}) - $signed({1'b0, a0});
        diff_b = $signed({1'b0, b1}) - $signed({1'b0, b0});
        case (r_state)
            ST_MUL_A: mul_a = MUL_AW'(diff_a);
            ST_MUL_B: mul_a = MUL_AW'(diff_b);
            default:  mul_a = r_n - r_s;
        endcase
        mul_b   = (r_state == ST_MUL_Y) ? $signed({1'b0, r_fy}) : $signed({1'b0, r_fx});
        mul_p   = mul_a * mul_b;
        round_v = MUL_PW'({r_s, {FRAC_W{1'b0}}}) + r_prod + MUL_PW'(64'h8000_0000);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= RST_SRC_SIZE;
            r_sh <= RST_SRC_SIZE;
            r_tw <= RST_DST_SIZE;
            r_th <= RST_DST_SIZE;
        end else if (cfg_acc) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SRC_WIDTH:  r_sw <= i_cfg.data[SRC_SIZE_W-1:0];
                CFG_SRC_HEIGHT: r_sh <= i_cfg.data[SRC_SIZE_W-1:0];
                CFG_DST_WIDTH:  r_tw <= i_cfg.data;
                CFG_DST_HEIGHT: r_th <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_axis      <= 1'b0;
            r_fcnt      <= '0;
            r_ch        <= '0;
            r_dcnt      <= '0;
        end else begin
            // the done state reloads the output register itself
            if (out_acc && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && t_mode'(i_pix.mode) == MODE_READ) begin
                        r_col  <= i_pix.column;
                        r_row  <= i_pix.line;
                        r_bad  <= req_bad;
                        r_axis <= 1'b0;
                        r_state <= req_bad ? ST_DONE : ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_dvd   <= {PW'(PW'(coord_sel) * PW'(s_ex_sel)), {FRAC_W{1'b0}}};
                    r_rem   <= '0;
                    r_div   <= d_ex_sel;
                    r_dcnt  <= '0;
                    r_state <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (r_dcnt == DIV_STEPS) begin
                        if (r_axis) begin
                            r_y0    <= ax_lo;
                            r_y1    <= ax_hi;
                            r_fy    <= ax_frac;
                            r_fcnt  <= '0;
                            r_state <= ST_FETCH;
                        end else begin
                            r_x0    <= ax_lo;
                            r_x1    <= ax_hi;
                            r_fx    <= ax_frac;
                            r_axis  <= 1'b1;
                            r_state <= ST_SETUP;
                        end
                    end else begin
                        r_rem  <= div_ge ? DST_SIZE_W'(div_trial - {1'b0, r_div})
                                         : div_trial[DST_SIZE_W-1:0];
                        r_dvd  <= {r_dvd[DW-2:0], div_ge};
                        r_dcnt <= r_dcnt + CW'(1);
                    end
                end
                ST_FETCH: begin
                    // Read data is registered in the store, so it lags its address
                    if (r_fcnt != '0) begin
                        r_pix[2'(r_fcnt - 3'd1)] <= r_rd_data;
                    end
                    if (r_fcnt == 3'd4) begin
                        r_ch    <= '0;
                        r_state <= ST_MUL_A;
                    end else begin
                        r_fcnt <= r_fcnt + 3'd1;
                    end
                end
                ST_MUL_A: begin
                    r_prod  <= mul_p;
                    r_state <= ST_MUL_B;
                end
                ST_MUL_B: begin
                    r_s     <= MUL_AW'({1'b0, a0, {FRAC_W{1'b0}}}) + r_prod[MUL_AW-1:0];
                    r_prod  <= mul_p;
                    r_state <= ST_SUM_N;
                end
                ST_SUM_N: begin
                    r_n     <= MUL_AW'({1'b0, b0, {FRAC_W{1'b0}}}) + r_prod[MUL_AW-1:0];
                    r_state <= ST_MUL_Y;
                end
                ST_MUL_Y: begin
                    r_prod  <= mul_p;
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_res[r_ch] <= round_v[2*FRAC_W +: CHAN_W];
                    if (r_ch == LAST_CH) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= ST_MUL_A;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || o_pix.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_bad   <= r_bad;
                        r_out_r     <= r_bad ? '0 : r_res[0];
                        r_out_g     <= r_bad ? '0 : r_res[1];
                        r_out_b     <= r_bad ? '0 : r_res[2];
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Partial remainder never reaches the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE && r_div != '0) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    // Upper neighbour is the lower one or the next
    a_neighbours: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |->
        ((r_x1 == r_x0 || r_x1 == r_x0 + IW'(1)) && (r_y1 == r_y0 || r_y1 == r_y0 + IW'(1))))
        else $error("neighbour indexes inconsistent");

    // A rejected request carries no colour
    a_bad_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.bad_request) |->
        (o_pix.red_out == '0 && o_pix.green_out == '0 && o_pix.blue_out == '0))
        else $error("bad request with colour");

    // A finished pixel waits while the output register is still held
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !o_pix.ready) |=>
        (r_state == ST_DONE && r_out_valid))
        else $error("result overwrote a waiting transaction");

endmodule
